// ===== hw/rtl/tile_type_blend_weight_filter_unit_assert.svh =====
// Assertion macros for the tile-type blend weight filter.
// Every macro expects signals named clk and arst_n in the scope where it is used.
`ifndef TILE_TYPE_BLEND_WEIGHT_FILTER_UNIT_ASSERT_SVH
`define TILE_TYPE_BLEND_WEIGHT_FILTER_UNIT_ASSERT_SVH

// Antecedent and consequent in the same cycle.
`define TBW_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent in the cycle after the antecedent.
`define TBW_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/tbw_pkg.sv =====
// Package for the tile-type blend weight filter: sizes, register indexes, types and
// the weight scaling function. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tbw_pkg;

	// Map and stream sizes.
	localparam int MAX_WIDTH   = 1024;
	localparam int COL_W       = $clog2(MAX_WIDTH);
	localparam int LAYERS      = 4;
	localparam int TILE_W      = 8;
	localparam int WEIGHT_W    = 8;
	localparam int CNT_W       = 3;
	localparam int ROW_WIDTH_W = 11;
	localparam int LAYER_CNT_W = 3;

	// Weight per matching neighbour: full scale spread over five taps.
	localparam int WEIGHT_STEP = 255 / 5;

	// Configuration port.
	localparam int PADDR_W   = 3;
	localparam int PDATA_W   = 32;
	localparam int REG_IDX_W = 1;
	localparam logic [REG_IDX_W-1:0] REG_ROW_WIDTH   = 1'b0;
	localparam logic [REG_IDX_W-1:0] REG_LAYER_COUNT = 1'b1;

	localparam logic [ROW_WIDTH_W-1:0] ROW_WIDTH_RST   = 11'd256;
	localparam logic [LAYER_CNT_W-1:0] LAYER_COUNT_RST = 3'd3;

	// One line buffer entry: the previous row and the row before it at one column.
	typedef struct packed {
		logic [TILE_W-1:0] prev;
		logic [TILE_W-1:0] up;
	} lb_entry_t;

	// Which neighbours of the centre pixel lie inside the map.
	typedef struct packed {
		logic has_left;
		logic has_up;
		logic has_right;
		logic has_down;
	} nbr_t;

	// One result item.
	typedef struct packed {
		logic [LAYERS-1:0][WEIGHT_W-1:0] weight;
		logic                            frame_end;
	} result_t;

	// Scale a match count of zero to five onto the weight range.
	function automatic logic [WEIGHT_W-1:0] weight_of(input logic [CNT_W-1:0] count);
		int scaled;
		scaled = WEIGHT_STEP * int'(count);
		return WEIGHT_W'(scaled);
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/tbw_if.sv =====
// Stream interfaces of the tile-type blend weight filter: tile requests in, weight
// requests out. Depends on tbw_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface tbw_in_if import tbw_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [TILE_W-1:0] tile_type;
	logic              pad_row;

	modport source (output valid, output tile_type, output pad_row, input ready);
	modport sink (input valid, input tile_type, input pad_row, output ready);
endinterface

interface tbw_out_if import tbw_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [WEIGHT_W-1:0] weight_layer0;
	logic [WEIGHT_W-1:0] weight_layer1;
	logic [WEIGHT_W-1:0] weight_layer2;
	logic [WEIGHT_W-1:0] weight_layer3;
	logic                frame_end;

	modport source (output valid, output weight_layer0, output weight_layer1,
		output weight_layer2, output weight_layer3, output frame_end, input ready);
	modport sink (input valid, input weight_layer0, input weight_layer1,
		input weight_layer2, input weight_layer3, input frame_end, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/tbw_line_buf.sv =====
// Line buffer holding the previous map row and the row before it, one entry per column.
// One write and one registered read per cycle. Depends on tbw_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tbw_line_buf import tbw_pkg::*; (
	input  wire logic             clk,
	input  wire logic             wr_en,
	input  wire logic [COL_W-1:0] wr_addr,
	input  wire lb_entry_t        wr_data,
	input  wire logic             rd_en,
	input  wire logic [COL_W-1:0] rd_addr,
	input  wire logic             rd_bypass,
	output lb_entry_t             rd_data
);

	lb_entry_t mem [MAX_WIDTH];
	lb_entry_t rd_data_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Registered read; the bypass forwards an entry written at the same edge.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			if (rd_bypass) begin
				rd_data_q <= wr_data;
			end else begin
				rd_data_q <= mem[rd_addr];
			end
		end
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

// ===== hw/rtl/tbw_cell.sv =====
// Window cell: holds one tile code of the filter window and flags which layer it matches.
// Cells hand their code to the neighbour on every accepted request. Depends on tbw_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tbw_cell import tbw_pkg::*; (
	input  wire logic              clk,
	input  wire logic              shift_en,
	input  wire logic [TILE_W-1:0] d,
	output logic [TILE_W-1:0]      q,
	output logic [LAYERS-1:0]      hit
);

	logic [TILE_W-1:0] val_q;

	// Take the code from the neighbour or the line buffer.
	always_ff @(posedge clk) begin
		if (shift_en) begin
			val_q <= d;
		end
	end

	// Layer match flags.
	always_comb begin
		for (int i = 0; i < LAYERS; i++) begin
			hit[i] = (val_q == TILE_W'(i));
		end
	end

	assign q = val_q;

endmodule

`default_nettype wire

// ===== hw/rtl/tbw_weight.sv =====
// Weight unit: counts the matching window taps per layer and scales the counts.
// Purely combinational. Depends on tbw_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tbw_weight import tbw_pkg::*; (
	input  wire logic [LAYERS-1:0]   hit_centre,
	input  wire logic [LAYERS-1:0]   hit_left,
	input  wire logic [LAYERS-1:0]   hit_up,
	input  wire logic [TILE_W-1:0]   right_val,
	input  wire logic [TILE_W-1:0]   down_val,
	input  wire nbr_t                nbr,
	input  wire logic [LAYERS-1:0]   layer_en,
	output logic [LAYERS-1:0][WEIGHT_W-1:0] weight
);

	logic [LAYERS-1:0] hit_right;
	logic [LAYERS-1:0] hit_down;
	logic [CNT_W-1:0]  count [LAYERS];

	// Count the taps inside the map that carry each layer's code.
	always_comb begin
		for (int i = 0; i < LAYERS; i++) begin
			hit_right[i] = (right_val == TILE_W'(i));
			hit_down[i]  = (down_val == TILE_W'(i));
			count[i] = CNT_W'(hit_centre[i])
				+ CNT_W'(hit_left[i] & nbr.has_left)
				+ CNT_W'(hit_up[i] & nbr.has_up)
				+ CNT_W'(hit_right[i] & nbr.has_right)
				+ CNT_W'(hit_down[i] & nbr.has_down);
			weight[i] = layer_en[i] ? weight_of(count[i]) : '0;
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/tbw_out_skid.sv =====
// Output register with a skid entry, so a new request is taken while a result waits.
// Depends on tbw_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tbw_out_skid import tbw_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    push,
	input  wire result_t push_data,
	output logic         full,
	output logic         out_valid,
	input  wire logic    out_ready,
	output result_t      out_data
);

	logic    main_valid_q;
	logic    skid_valid_q;
	result_t main_q;
	result_t skid_q;
	logic    pop;

	assign pop = main_valid_q && out_ready;

	// Valid flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (pop) begin
				skid_valid_q <= 1'b0;
			end
		end else if (push) begin
			if (main_valid_q && !pop) begin
				skid_valid_q <= 1'b1;
			end
			main_valid_q <= 1'b1;
		end else if (pop) begin
			main_valid_q <= 1'b0;
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (pop) begin
				main_q <= skid_q;
			end
		end else if (push) begin
			if (main_valid_q && !pop) begin
				skid_q <= push_data;
			end else begin
				main_q <= push_data;
			end
		end
	end

	assign full      = skid_valid_q;
	assign out_valid = main_valid_q;
	assign out_data  = main_q;

endmodule

`default_nettype wire

// ===== hw/rtl/tile_type_blend_weight_filter_unit.sv =====
// The result for an accepted tile request is registered in the output stage; the pixel
// it belongs to lies one map row above that tile, so output trails input by one row.
// Throughput: one tile per cycle, from the separate write and read ports of the line buffer;
// tile requests stall only while the output register and its skid entry both hold results.
// Reset clears the column and row counters and output valid flags and loads the default
// configuration, not the line buffer; the first map row of each frame gives no results.
`timescale 1ns / 1ps
`default_nettype none

module tile_type_blend_weight_filter_unit import tbw_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	tbw_in_if.sink                  tiles,
	tbw_out_if.source               weights,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0]      prdata,
	output logic                    pready
);

	localparam logic [1:0] ROWS_FULL = 2'd2;

	logic [ROW_WIDTH_W-1:0] row_width_q;
	logic [LAYER_CNT_W-1:0] layer_count_q;
	logic [COL_W-1:0]       col_q;
	logic [1:0]             rows_q;
	lb_entry_t              entry0_q;

	logic                   cfg_wr;
	logic [REG_IDX_W-1:0]   reg_idx;
	logic [ROW_WIDTH_W-1:0] last_col;
	logic [ROW_WIDTH_W-1:0] col_ext;
	logic                   last;
	logic                   accept;
	logic                   push;
	logic                   skid_full;
	lb_entry_t              wr_data;
	lb_entry_t              rd_data;
	lb_entry_t              wrap_src;
	logic [COL_W-1:0]       rd_addr;
	logic                   rd_bypass;
	logic [TILE_W-1:0]      centre_val;
	logic [TILE_W-1:0]      left_val;
	logic [TILE_W-1:0]      up_val;
	logic [TILE_W-1:0]      centre_d;
	logic [TILE_W-1:0]      up_d;
	logic [LAYERS-1:0]      hit_centre;
	logic [LAYERS-1:0]      hit_left;
	logic [LAYERS-1:0]      hit_up;
	logic [LAYERS-1:0]      layer_en;
	nbr_t                   nbr;
	result_t                result;
	result_t                out_data;

	// Configuration port: register writes and read-back.
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign reg_idx = paddr[2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_width_q   <= ROW_WIDTH_RST;
			layer_count_q <= LAYER_COUNT_RST;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_ROW_WIDTH:   row_width_q   <= pwdata[ROW_WIDTH_W-1:0];
				REG_LAYER_COUNT: layer_count_q <= pwdata[LAYER_CNT_W-1:0];
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_ROW_WIDTH:   prdata = PDATA_W'(row_width_q);
			REG_LAYER_COUNT: prdata = PDATA_W'(layer_count_q);
		endcase
	end

	// Last column of a row, with the width clamped to the supported range.
	always_comb begin
		if (row_width_q == '0) begin
			last_col = '0;
		end else if (row_width_q > ROW_WIDTH_W'(MAX_WIDTH)) begin
			last_col = ROW_WIDTH_W'(MAX_WIDTH - 1);
		end else begin
			last_col = row_width_q - ROW_WIDTH_W'(1);
		end
	end

	assign col_ext = ROW_WIDTH_W'(col_q);
	assign last    = (col_ext >= last_col);
	assign accept  = tiles.valid && tiles.ready;
	assign push    = accept && (rows_q != 2'd0);

	// Column and row counters; a pad request in the last column ends the frame.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			rows_q <= 2'd0;
		end else if (accept) begin
			if (last) begin
				col_q <= '0;
				if (tiles.pad_row) begin
					rows_q <= 2'd0;
				end else if (rows_q != ROWS_FULL) begin
					rows_q <= rows_q + 2'd1;
				end
			end else begin
				col_q <= col_q + COL_W'(1);
			end
		end
	end

	// Entry written back for this column; column zero is also kept for the row wrap.
	assign wr_data = '{prev: tiles.tile_type, up: centre_val};

	always_ff @(posedge clk) begin
		if (accept && (col_q == '0)) begin
			entry0_q <= wr_data;
		end
	end

	// Prefetch the entry right of the next centre: two ahead within a row, column one
	// at the wrap, forwarded from the write when that column is written now.
	assign rd_addr   = last ? COL_W'(1) : col_q + COL_W'(2);
	assign rd_bypass = last && (col_q == COL_W'(1));

	tbw_line_buf u_line_buf (
		.clk       (clk),
		.wr_en     (accept),
		.wr_addr   (col_q),
		.wr_data   (wr_data),
		.rd_en     (accept),
		.rd_addr   (rd_addr),
		.rd_bypass (rd_bypass),
		.rd_data   (rd_data)
	);

	// Window cells: the right entry moves into the centre, the centre moves left.
	assign wrap_src = (col_q == '0) ? wr_data : entry0_q;
	assign centre_d = last ? wrap_src.prev : rd_data.prev;
	assign up_d     = last ? wrap_src.up : rd_data.up;

	tbw_cell u_cell_centre (
		.clk      (clk),
		.shift_en (accept),
		.d        (centre_d),
		.q        (centre_val),
		.hit      (hit_centre)
	);

	tbw_cell u_cell_left (
		.clk      (clk),
		.shift_en (accept),
		.d        (centre_val),
		.q        (left_val),
		.hit      (hit_left)
	);

	tbw_cell u_cell_up (
		.clk      (clk),
		.shift_en (accept),
		.d        (up_d),
		.q        (up_val),
		.hit      (hit_up)
	);

	// Neighbour presence and layer enables.
	assign nbr.has_left  = (col_q != '0) && (left_val == left_val);
	assign nbr.has_up    = (rows_q == ROWS_FULL) && (up_val == up_val);
	assign nbr.has_right = !last;
	assign nbr.has_down  = !tiles.pad_row;

	always_comb begin
		for (int i = 0; i < LAYERS; i++) begin
			layer_en[i] = (layer_count_q > LAYER_CNT_W'(i));
		end
	end

	tbw_weight u_weight (
		.hit_centre (hit_centre),
		.hit_left   (hit_left),
		.hit_up     (hit_up),
		.right_val  (rd_data.prev),
		.down_val   (tiles.tile_type),
		.nbr        (nbr),
		.layer_en   (layer_en),
		.weight     (result.weight)
	);

	assign result.frame_end = tiles.pad_row && last;

	// Output register with skid entry.
	tbw_out_skid u_out_skid (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (result),
		.full      (skid_full),
		.out_valid (weights.valid),
		.out_ready (weights.ready),
		.out_data  (out_data)
	);

	assign tiles.ready           = !skid_full;
	assign weights.weight_layer0 = out_data.weight[0];
	assign weights.weight_layer1 = out_data.weight[1];
	assign weights.weight_layer2 = out_data.weight[2];
	assign weights.weight_layer3 = out_data.weight[3];
	assign weights.frame_end     = out_data.frame_end;

endmodule

`default_nettype wire

// ===== hw/rtl/tbw_checker.sv =====
// Port-level checker for the tile-type blend weight filter, bound to the top level.
// Depends on tbw_pkg and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none

`include "tile_type_blend_weight_filter_unit_assert.svh"

module tbw_checker import tbw_pkg::*; (
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                in_valid,
	input wire logic                in_ready,
	input wire logic                out_valid,
	input wire logic                out_ready,
	input wire logic [WEIGHT_W-1:0] w0,
	input wire logic [WEIGHT_W-1:0] w1,
	input wire logic [WEIGHT_W-1:0] w2,
	input wire logic [WEIGHT_W-1:0] w3,
	input wire logic                frame_end
);

	// Each tap matches at most one layer, so the weights of a pixel never exceed full scale.
	`TBW_ASSERT_IMP(a_weight_sum, out_valid, (10'(w0) + 10'(w1) + 10'(w2) + 10'(w3)) <= 10'd255, "weights of one pixel exceed full scale")

	// A result only appears after a tile request has been taken.
	`TBW_ASSERT_IMP(a_no_spurious_result, $rose(out_valid), $past(in_valid && in_ready), "result without a preceding tile request")

	// Input back-pressure only while a result is waiting.
	`TBW_ASSERT_IMP(a_stall_has_cause, !in_ready, out_valid, "input stalled with no result pending")

	// A stalled result holds its payload.
	`TBW_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(w0) && $stable(w1) && $stable(w2) && $stable(w3) && $stable(frame_end), "stalled result changed")

endmodule

bind tile_type_blend_weight_filter_unit tbw_checker u_tbw_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (tiles.valid),
	.in_ready  (tiles.ready),
	.out_valid (weights.valid),
	.out_ready (weights.ready),
	.w0        (weights.weight_layer0),
	.w1        (weights.weight_layer1),
	.w2        (weights.weight_layer2),
	.w3        (weights.weight_layer3),
	.frame_end (weights.frame_end)
);

`default_nettype wire
